[sv/assert_macros.svh]
// Assertion macros used by the RTL of the slot allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error("assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/flsa_pkg.sv]
// Types and constants of the free list slot allocator.
package flsa_pkg;

  localparam int SLOT_W = 10;
  localparam int STAT_W = 2;
  localparam int COUNT_W = 11;
  localparam int OFF_W = 32;
  localparam int ESZ_W = 16;

  typedef enum logic [1:0] {
    CMD_TAKE   = 2'd0,
    CMD_RETURN = 2'd1,
    CMD_LOCATE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_RANGE     = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_DIV
  } state_t;

  typedef struct packed {
    cmd_t              command;
    logic [SLOT_W-1:0] slot_index;
    logic [OFF_W-1:0]  byte_offset;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    status_t            status;
    logic [COUNT_W-1:0] in_use_count;
  } out_item_t;

endpackage

[sv/flsa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module flsa_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/flsa_div.sv]
// Restoring divider, one quotient bit per cycle, for offset to slot translation.
module flsa_div
  import flsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [OFF_W-1:0] dividend,
  input  logic [ESZ_W-1:0] divisor,
  output logic             done,
  output logic [OFF_W-1:0] quotient
);

  localparam int CW = $clog2(OFF_W);

  logic [OFF_W-1:0] quot_r, quot_nxt;
  logic [ESZ_W-1:0] rem_r, rem_nxt;
  logic [ESZ_W-1:0] dsr_r, dsr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [ESZ_W:0]   trial;
  logic [ESZ_W:0]   diff;
  logic             fits;

  always_comb begin
    trial = {rem_r, quot_r[OFF_W-1]};
    diff  = trial - {1'b0, dsr_r};
    fits  = (trial >= {1'b0, dsr_r});
  end

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CW'(OFF_W - 1);
      run_nxt  = 1'b1;
    end else if (run_r) begin
      quot_nxt = {quot_r[OFF_W-2:0], fits};
      rem_nxt  = fits ? diff[ESZ_W-1:0] : trial[ESZ_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

[sv/free_list_slot_allocator_unit.sv]
// Top level of the free list slot allocator.
//
// Commands enter on in_item with start; a transfer happens at a clock edge where
// start is high and busy is low. Each command gives exactly one result on
// out_item, marked by out_strobe for a single cycle; the receiver always takes it.
// Take pops the free stack or hands out a fresh slot, return pushes a slot,
// locate divides the byte offset by element_size, clear empties the pool.
// element_size is written through cfg_we/cfg_wdata; write it only while the
// block is idle; the block does not enforce it. A take from the stack reads
// the RAM in ST_EXEC and answers from ST_READ; locate with a nonzero size answers
// from ST_DIV when the divider, one bit per cycle, is done; others from ST_EXEC.
// busy stays high from the transfer until the cycle before out_strobe, so a new
// command may be taken in the cycle its predecessor's result is shown.
// Reset empties the pool, sets element_size to 1 and needs no clearing pass;
// only stack RAM data read below the fill count is used.
module free_list_slot_allocator_unit
  import flsa_pkg::*;
#(
  parameter int POOL_DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_item,
  output logic             out_strobe,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [ESZ_W-1:0] cfg_wdata
);

  localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
  localparam int ADDR_W = $clog2(POOL_DEPTH);
  localparam int HAND_W = CNT_W + 1;

  state_t           state_r, state_nxt;
  in_item_t         item_r;
  logic [CNT_W-1:0] stack_r, stack_nxt;
  logic [CNT_W-1:0] taken_r, taken_nxt;
  logic [ESZ_W-1:0] esize_r;
  out_item_t        out_r, out_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  logic [HAND_W-1:0] handed;
  logic [CNT_W-1:0] stack_dec;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [SLOT_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [SLOT_W-1:0] ram_rdata;

  logic             div_start;
  logic             div_done;
  logic [OFF_W-1:0] div_quot;

  assign handed    = {1'b0, taken_r} + {1'b0, stack_r};
  assign stack_dec = stack_r - 1'b1;
  assign ram_raddr = stack_dec[ADDR_W-1:0];
  assign ram_waddr = stack_r[ADDR_W-1:0];
  assign ram_wdata = item_r.slot_index;

  flsa_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(POOL_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  flsa_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(item_r.byte_offset),
    .divisor (esize_r),
    .done    (div_done),
    .quotient(div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (item_r.command)
          CMD_TAKE:   state_nxt = (stack_r != '0) ? ST_READ : ST_IDLE;
          CMD_LOCATE: state_nxt = (esize_r != '0) ? ST_DIV : ST_IDLE;
          default:    state_nxt = ST_IDLE;
        endcase
      end
      ST_READ: state_nxt = ST_IDLE;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    stack_nxt      = stack_r;
    taken_nxt      = taken_r;
    out_nxt        = out_r;
    out_strobe_nxt = 1'b0;
    ram_we         = 1'b0;
    div_start      = 1'b0;
    unique case (state_r)
      ST_EXEC: begin
        unique case (item_r.command)
          CMD_TAKE: begin
            if (stack_r != '0) begin
              stack_nxt = stack_dec;
              taken_nxt = taken_r + 1'b1;
            end else if (taken_r < CNT_W'(POOL_DEPTH)) begin
              taken_nxt      = taken_r + 1'b1;
              out_strobe_nxt = 1'b1;
              out_nxt.slot   = SLOT_W'(taken_r);
              out_nxt.status = STAT_OK;
            end else begin
              out_strobe_nxt = 1'b1;
              out_nxt.slot   = '0;
              out_nxt.status = STAT_EXHAUSTED;
            end
          end
          CMD_RETURN: begin
            out_strobe_nxt = 1'b1;
            out_nxt.slot   = '0;
            if (taken_r == '0 || 32'(item_r.slot_index) >= 32'(handed)) begin
              out_nxt.status = STAT_RANGE;
            end else if (stack_r >= CNT_W'(POOL_DEPTH)) begin
              out_nxt.status = STAT_FULL;
            end else begin
              ram_we         = 1'b1;
              stack_nxt      = stack_r + 1'b1;
              taken_nxt      = taken_r - 1'b1;
              out_nxt.status = STAT_OK;
            end
          end
          CMD_LOCATE: begin
            if (esize_r == '0) begin
              out_strobe_nxt = 1'b1;
              out_nxt.slot   = '0;
              out_nxt.status = STAT_RANGE;
            end else begin
              div_start = 1'b1;
            end
          end
          CMD_CLEAR: begin
            stack_nxt      = '0;
            taken_nxt      = '0;
            out_strobe_nxt = 1'b1;
            out_nxt.slot   = '0;
            out_nxt.status = STAT_OK;
          end
          default: ;
        endcase
      end
      ST_READ: begin
        out_strobe_nxt = 1'b1;
        out_nxt.slot   = ram_rdata;
        out_nxt.status = STAT_OK;
      end
      ST_DIV: begin
        if (div_done) begin
          out_strobe_nxt = 1'b1;
          if (div_quot >= 32'(handed)) begin
            out_nxt.slot   = '0;
            out_nxt.status = STAT_RANGE;
          end else begin
            out_nxt.slot   = div_quot[SLOT_W-1:0];
            out_nxt.status = STAT_OK;
          end
        end
      end
      default: ;
    endcase
    if (out_strobe_nxt) begin
      out_nxt.in_use_count = COUNT_W'(taken_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      stack_r      <= '0;
      taken_r      <= '0;
      esize_r      <= ESZ_W'(1);
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      stack_r      <= stack_nxt;
      taken_r      <= taken_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        esize_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      item_r <= in_item;
    end
    out_r <= out_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_handed_bound, clk, rst_n, handed <= HAND_W'(POOL_DEPTH))
  `ASSERT_IMPL(a_strobe_idle, clk, rst_n, out_strobe_r, state_r == ST_IDLE)
  `ASSERT_NEXT(a_accept_exec, clk, rst_n, start && !busy, state_r == ST_EXEC)
  `ASSERT_IMPL(a_push_room, clk, rst_n, ram_we, stack_r < CNT_W'(POOL_DEPTH))

endmodule

[dv/tb.sv]
// Self-checking testbench for the free list slot allocator: directed and random command streams.
module tb;
  import flsa_pkg::*;

  localparam int DEPTH      = 1024;
  localparam int STALL_MAX  = 2000;
  localparam int SHOW_MAX   = 50;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  logic                busy;
  in_item_t            in_item   = '0;
  logic                out_strobe;
  out_item_t           out_item;
  logic                cfg_we    = 1'b0;
  logic [ESZ_W-1:0]    cfg_wdata = '0;

  in_item_t            cmd_backlog[$];
  out_item_t           slot_answers[$];
  out_item_t           want;
  int                  idle_pct    = 0;
  int                  fail_count  = 0;
  int                  quiet_count = 0;

  // allocator image, updated as commands transfer
  logic [SLOT_W-1:0]   model_free[DEPTH];
  int                  model_free_cnt = 0;
  int                  model_taken    = 0;
  logic [ESZ_W-1:0]    model_esize    = 16'd1;

  // counts as the stream stands once every queued command has run
  int                  gen_free  = 0;
  int                  gen_taken = 0;
  logic [ESZ_W-1:0]    gen_esize = 16'd1;

  free_list_slot_allocator_unit #(.POOL_DEPTH(DEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic out_item_t allocate_step(in_item_t it);
    out_item_t        r;
    int               handed;
    longint unsigned  quot;
    r = '0;
    r.status = STAT_OK;
    handed = model_taken + model_free_cnt;
    case (it.command)
      CMD_TAKE: begin
        if (model_free_cnt > 0) begin
          model_free_cnt--;
          r.slot = model_free[model_free_cnt];
          model_taken++;
        end else if (model_taken < DEPTH) begin
          r.slot = SLOT_W'(model_taken);
          model_taken++;
        end else begin
          r.status = STAT_EXHAUSTED;
        end
      end
      CMD_RETURN: begin
        if (model_taken == 0 || int'(it.slot_index) >= handed) begin
          r.status = STAT_RANGE;
        end else if (model_free_cnt >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          model_free[model_free_cnt] = it.slot_index;
          model_free_cnt++;
          model_taken--;
        end
      end
      CMD_LOCATE: begin
        if (model_esize == '0) begin
          r.status = STAT_RANGE;
        end else begin
          quot = longint'(it.byte_offset) / longint'(model_esize);
          if (quot >= longint'(handed)) r.status = STAT_RANGE;
          else r.slot = SLOT_W'(quot);
        end
      end
      default: begin
        model_free_cnt = 0;
        model_taken = 0;
      end
    endcase
    r.in_use_count = COUNT_W'(model_taken);
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    fail_count++;
    if (fail_count <= SHOW_MAX) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic backlog_push(cmd_t c, int s, logic [OFF_W-1:0] o);
    in_item_t it;
    it.command = c;
    it.slot_index = SLOT_W'(s);
    it.byte_offset = o;
    case (c)
      CMD_TAKE: begin
        if (gen_free > 0) begin
          gen_free--;
          gen_taken++;
        end else if (gen_taken < DEPTH) begin
          gen_taken++;
        end
      end
      CMD_RETURN: begin
        if (gen_taken > 0 && s < gen_taken + gen_free && gen_free < DEPTH) begin
          gen_free++;
          gen_taken--;
        end
      end
      CMD_CLEAR: begin
        gen_free = 0;
        gen_taken = 0;
      end
      default: ;
    endcase
    cmd_backlog.push_back(it);
  endtask

  task automatic random_cmd(int take_to, int ret_to, int loc_to);
    int               roll;
    int               handed;
    int               s;
    logic [OFF_W-1:0] o;
    roll = $urandom_range(99);
    handed = gen_taken + gen_free;
    s = $urandom_range(DEPTH - 1);
    o = $urandom;
    if (roll < take_to) begin
      backlog_push(CMD_TAKE, s, o);
    end else if (roll < ret_to) begin
      if (handed > 0 && $urandom_range(99) < 85) s = $urandom_range(handed - 1);
      backlog_push(CMD_RETURN, s, o);
    end else if (roll < loc_to) begin
      roll = $urandom_range(99);
      if (gen_esize != '0 && handed > 0 && roll < 55) begin
        o = OFF_W'($urandom_range(handed - 1)) * gen_esize
            + OFF_W'($urandom_range(int'(gen_esize) - 1));
      end else if (gen_esize != '0 && roll < 70) begin
        o = OFF_W'(handed) * gen_esize - OFF_W'($urandom_range(1));
      end
      backlog_push(CMD_LOCATE, s, o);
    end else begin
      backlog_push(CMD_CLEAR, s, o);
    end
  endtask

  task automatic await_quiet();
    while (cmd_backlog.size() != 0 || start || slot_answers.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(logic [ESZ_W-1:0] esize, int idle, int count,
                           int take_to, int ret_to, int loc_to);
    await_quiet();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= esize;
    model_esize = esize;
    gen_esize = esize;
    @(posedge clk);
    cfg_we <= 1'b0;
    idle_pct = idle;
    repeat (count) random_cmd(take_to, ret_to, loc_to);
  endtask

  // driver: hold an offered command until busy drops, then advance
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) slot_answers.push_back(allocate_step(in_item));
      if (start && busy) begin
        start <= 1'b1;
      end else if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        in_item <= cmd_backlog.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobed result must match the answer queued at a transfer
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (slot_answers.size() == 0) begin
        flag_mismatch("result with nothing outstanding");
      end else begin
        want = slot_answers.pop_front();
        if (out_item.slot !== want.slot)
          flag_mismatch($sformatf("slot %0d, want %0d", out_item.slot, want.slot));
        if (out_item.status !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", out_item.status, want.status));
        if (out_item.in_use_count !== want.in_use_count)
          flag_mismatch($sformatf("in_use_count %0d, want %0d",
                                  out_item.in_use_count, want.in_use_count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) quiet_count <= 0;
      else quiet_count <= quiet_count + 1;
      if (quiet_count >= STALL_MAX) begin
        $display("watchdog: no transfer for %0d cycles", STALL_MAX);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    backlog_push(CMD_LOCATE, 0, 32'd0);
    backlog_push(CMD_RETURN, 0, 32'd0);
    backlog_push(CMD_TAKE, 0, 32'd0);
    backlog_push(CMD_TAKE, 0, 32'd0);
    backlog_push(CMD_TAKE, 0, 32'd0);
    backlog_push(CMD_LOCATE, 0, 32'd2);
    backlog_push(CMD_LOCATE, 0, 32'd3);
    backlog_push(CMD_LOCATE, 10'h3FF, 32'hFFFF_FFFF);
    backlog_push(CMD_RETURN, 10'h3FF, 32'hFFFF_FFFF);
    backlog_push(CMD_RETURN, 1, 32'd0);
    backlog_push(CMD_TAKE, 0, 32'd0);
    backlog_push(CMD_RETURN, 0, 32'd0);
    backlog_push(CMD_RETURN, 2, 32'd0);
    backlog_push(CMD_TAKE, 0, 32'd0);
    backlog_push(CMD_TAKE, 0, 32'd0);
    backlog_push(CMD_RETURN, 2, 32'd0);
    backlog_push(CMD_RETURN, 2, 32'd0);
    backlog_push(CMD_TAKE, 0, 32'd0);
    backlog_push(CMD_TAKE, 0, 32'd0);
    backlog_push(CMD_CLEAR, 10'h3FF, 32'hFFFF_FFFF);
    backlog_push(CMD_TAKE, 0, 32'd0);
    backlog_push(CMD_LOCATE, 0, 32'd0);
    backlog_push(CMD_CLEAR, 0, 32'd0);

    run_phase(16'd0,     47,   60, 36, 68, 97);
    run_phase(16'hFFFF,  30,  200, 36, 68, 97);
    run_phase(16'd3,      0, 1100, 96, 98, 100);
    run_phase(16'd1,     47,  250, 36, 68, 98);

    await_quiet();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
